### rtl/psram_controller_register_banks_assert.svh
// Assertion macros used by the register bank top level.
`ifndef PSRAM_CONTROLLER_REGISTER_BANKS_ASSERT_SVH
`define PSRAM_CONTROLLER_REGISTER_BANKS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PRB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("psram register banks: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PRB_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("psram register banks: next-cycle check failed");

`endif

### rtl/prb_pkg.sv
// Shared types, codes and helper functions of the PSRAM register banks.
`default_nettype none

package prb_pkg;

    // Request types.
    localparam logic [1:0] REQ_READ       = 2'd0;
    localparam logic [1:0] REQ_WRITE      = 2'd1;
    localparam logic [1:0] REQ_CLOCK_GATE = 2'd2;
    localparam logic [1:0] REQ_RESET_LINE = 2'd3;

    // Bank select codes.
    localparam logic BANK_CTRL = 1'b0;
    localparam logic BANK_CMD  = 1'b1;

    // Control bank byte offsets.
    localparam logic [9:0] OFF_CFG_LAST   = 10'h010;
    localparam logic [9:0] OFF_STATUS     = 10'h014;
    localparam logic [9:0] OFF_IRQ_STATUS = 10'h018;
    localparam logic [9:0] OFF_IRQ_MASK   = 10'h01C;
    localparam logic [9:0] OFF_IRQ_CLEAR  = 10'h020;

    localparam int CFG_WORDS = 5;

    // One request as it travels through the pipeline.
    typedef struct packed {
        logic [1:0]  req_type;
        logic        bank;
        logic [9:0]  reg_offset;
        logic [31:0] write_data;
        logic        line_level;
    } prb_op_t;

    // Mode-register readback built from the basic word and config word 8.
    function automatic logic [7:0] mode_readback(input logic [31:0] basic_word,
                                                 input logic [31:0] cfg_word);
        logic [7:0] mode;
        logic [7:0] result;
        mode   = basic_word[15:8];
        result = '0;
        case (mode)
            8'd0: begin
                result = {1'b0, cfg_word[7:4], cfg_word[2:0]};
            end
            8'd2: begin
                result = {2'b00, cfg_word[10], cfg_word[9], cfg_word[8], 3'b000};
            end
            default: begin
                result = '0;
            end
        endcase
        return result;
    endfunction

endpackage

`default_nettype wire

### rtl/psram_controller_register_banks.sv
// Top level of the PSRAM controller register banks: request and result pipeline.
//
//   Channel   Prefix  Direction  Carries
//   request   s_      in         req_type, bank, reg_offset, write_data, line_level
//   result    m_      out        read_data, bad_offset
//
// A request is accepted into the request register, where it is decoded, the
// banks are updated and its result is captured in the result register; one
// request per cycle is sustained while m_ready stays high.
// The command bank word memory is read as the request is accepted, so its
// registered read data lines up with the request in the request register.
// Reset (aresetn low, synchronous) resets the valid flags and bank registers
// only; the memory entries are marked invalid by flip-flop valid bits, so no
// clearing pass runs. A stalled result holds the request register, and
// s_ready drops only when both stages are full and m_ready is low.
`default_nettype none

`include "psram_controller_register_banks_assert.svh"

module psram_controller_register_banks #(
    parameter int CMD_BANK_WORDS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic        s_bank,
    input  logic [9:0]  s_reg_offset,
    input  logic [31:0] s_write_data,
    input  logic        s_line_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_read_data,
    output logic        m_bad_offset
);
    import prb_pkg::*;

    // Request register stage.
    logic    st1_valid_reg, st1_valid_next;
    prb_op_t op_reg;

    // Result register stage.
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_read_data_reg;
    logic        m_bad_offset_reg;

    logic        accept;
    logic        advance;
    logic [31:0] ctrl_word, cmd_word;
    logic        ctrl_bad, cmd_bad;
    logic        is_access;
    logic        sel_bad;
    logic [31:0] res_data;
    logic        res_bad;

    // The request register moves on whenever the result register is free or
    // being emptied in the same cycle.
    assign advance = st1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !st1_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    assign st1_valid_next = accept || (st1_valid_reg && !advance);
    assign m_valid_next   = advance || (m_valid_reg && !m_ready);

    prb_ctrl_bank u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .op      (op_reg),
        .rd_word (ctrl_word),
        .bad     (ctrl_bad)
    );

    prb_cmd_bank #(
        .CMD_BANK_WORDS (CMD_BANK_WORDS)
    ) u_cmd (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_offset (s_reg_offset),
        .fire      (advance),
        .op        (op_reg),
        .rd_word   (cmd_word),
        .bad       (cmd_bad)
    );

    // Only bus reads return data; writes, events and bad offsets return zero.
    // Events never flag a bad offset.
    always_comb begin
        is_access = (op_reg.req_type == REQ_READ) || (op_reg.req_type == REQ_WRITE);
        sel_bad   = (op_reg.bank == BANK_CMD) ? cmd_bad : ctrl_bad;
        res_bad   = is_access && sel_bad;
        if ((op_reg.req_type == REQ_READ) && !sel_bad) begin
            res_data = (op_reg.bank == BANK_CMD) ? cmd_word : ctrl_word;
        end else begin
            res_data = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            st1_valid_reg <= st1_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg.req_type   <= s_req_type;
            op_reg.bank       <= s_bank;
            op_reg.reg_offset <= s_reg_offset;
            op_reg.write_data <= s_write_data;
            op_reg.line_level <= s_line_level;
        end
        if (advance) begin
            m_read_data_reg  <= res_data;
            m_bad_offset_reg <= res_bad;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_read_data  = m_read_data_reg;
    assign m_bad_offset = m_bad_offset_reg;

    `PRB_ASSERT_IMP(a_bad_reads_zero, aclk, aresetn, m_valid_reg && m_bad_offset_reg, m_read_data_reg == 32'd0)
    `PRB_ASSERT_IMP(a_stall_only_when_full, aclk, aresetn, !s_ready, st1_valid_reg && m_valid_reg && !m_ready)
    `PRB_ASSERT_NXT(a_advance_fills_result, aclk, aresetn, advance, m_valid_reg)
    `PRB_ASSERT_NXT(a_event_never_bad, aclk, aresetn, advance && (op_reg.req_type == REQ_CLOCK_GATE || op_reg.req_type == REQ_RESET_LINE), !m_bad_offset_reg)

endmodule

`default_nettype wire

### rtl/prb_ctrl_bank.sv
// Control register bank: config words, status snapshot, interrupt status and mask.
`default_nettype none

module prb_ctrl_bank (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             fire,
    input  prb_pkg::prb_op_t op,
    output logic [31:0]      rd_word,
    output logic             bad
);
    import prb_pkg::*;

    logic [31:0] cfg_reg [CFG_WORDS];
    logic [31:0] cfg_next [CFG_WORDS];
    logic [1:0]  status_reg, status_next;
    logic [31:0] irq_status_reg, irq_status_next;
    logic [31:0] irq_mask_reg, irq_mask_next;
    logic        clock_gate_reg, clock_gate_next;
    logic        reset_line_reg, reset_line_next;

    logic [2:0]  cidx;
    logic        in_cfg;
    logic        wr_hit;
    logic        refresh;
    logic [31:0] w0;

    assign cidx   = op.reg_offset[4:2];
    assign in_cfg = (op.reg_offset <= OFF_CFG_LAST);
    assign bad    = (op.reg_offset[1:0] != 2'b00) || (op.reg_offset > OFF_IRQ_CLEAR);
    assign wr_hit = fire && (op.req_type == REQ_WRITE) && (op.bank == BANK_CTRL) && !bad;

    // Read path.
    always_comb begin
        rd_word = '0;
        if (in_cfg) begin
            case (cidx)
                3'd0: begin
                    rd_word     = cfg_reg[0];
                    rd_word[17] = cfg_reg[0][17] | cfg_reg[0][16];
                end
                3'd1: rd_word = cfg_reg[1];
                3'd2: rd_word = cfg_reg[2];
                3'd3: rd_word = cfg_reg[3];
                3'd4: rd_word = cfg_reg[4];
                default: rd_word = '0;
            endcase
        end else if (op.reg_offset == OFF_STATUS) begin
            rd_word = {30'b0, status_reg};
        end else if (op.reg_offset == OFF_IRQ_STATUS) begin
            rd_word = irq_status_reg;
        end else if (op.reg_offset == OFF_IRQ_MASK) begin
            rd_word = irq_mask_reg;
        end
    end

    // Update path.
    always_comb begin
        for (int i = 0; i < CFG_WORDS; i++) begin
            cfg_next[i] = cfg_reg[i];
        end
        irq_status_next = irq_status_reg;
        irq_mask_next   = irq_mask_reg;
        clock_gate_next = clock_gate_reg;
        reset_line_next = reset_line_reg;
        refresh         = 1'b0;
        w0              = '0;

        if (fire && (op.req_type == REQ_CLOCK_GATE)) begin
            clock_gate_next = op.line_level;
            refresh         = 1'b1;
        end else if (fire && (op.req_type == REQ_RESET_LINE)) begin
            reset_line_next = op.line_level;
            refresh         = 1'b1;
            if (op.line_level) begin
                for (int i = 0; i < CFG_WORDS; i++) begin
                    cfg_next[i] = '0;
                end
                irq_status_next = '0;
                irq_mask_next   = '0;
            end
        end else if (wr_hit) begin
            if (in_cfg) begin
                if (cidx == 3'd0) begin
                    // Pulse bits are not stored; they are copied into the done flags instead.
                    w0      = op.write_data & ~32'h0003_F000 | (op.write_data & 32'h0001_0000);
                    w0[14]  = op.write_data[12];
                    w0[15]  = op.write_data[13];
                    cfg_next[0] = w0;
                    if (op.write_data[12] || op.write_data[13]) begin
                        irq_status_next[0] = 1'b1;
                    end
                    refresh = 1'b1;
                end else begin
                    cfg_next[cidx] = op.write_data;
                end
            end else if ((op.reg_offset == OFF_IRQ_STATUS) ||
                         (op.reg_offset == OFF_IRQ_CLEAR)) begin
                irq_status_next = irq_status_reg & ~op.write_data;
            end else if (op.reg_offset == OFF_IRQ_MASK) begin
                irq_mask_next = op.write_data;
            end
        end else if (fire && (op.req_type == REQ_WRITE) && (op.bank == BANK_CMD) &&
                     (op.reg_offset == 10'd0)) begin
            // A write to the command bank's basic word also refreshes status.
            refresh = 1'b1;
        end

        if (refresh) begin
            status_next = (clock_gate_next && !reset_line_next && cfg_next[0][0]) ?
                          2'b11 : 2'b00;
        end else begin
            status_next = status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CFG_WORDS; i++) begin
                cfg_reg[i] <= '0;
            end
            status_reg     <= '0;
            irq_status_reg <= '0;
            irq_mask_reg   <= '0;
            clock_gate_reg <= 1'b1;
            reset_line_reg <= 1'b0;
        end else begin
            for (int i = 0; i < CFG_WORDS; i++) begin
                cfg_reg[i] <= cfg_next[i];
            end
            status_reg     <= status_next;
            irq_status_reg <= irq_status_next;
            irq_mask_reg   <= irq_mask_next;
            clock_gate_reg <= clock_gate_next;
            reset_line_reg <= reset_line_next;
        end
    end

endmodule

`default_nettype wire

### rtl/prb_cmd_bank.sv
// Command register bank: word memory with valid bits and the special command words.
`default_nettype none

module prb_cmd_bank #(
    parameter int CMD_BANK_WORDS = 64
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             rd_en,
    input  logic [9:0]       rd_offset,
    input  logic             fire,
    input  prb_pkg::prb_op_t op,
    output logic [31:0]      rd_word,
    output logic             bad
);
    import prb_pkg::*;

    localparam int IW = $clog2(CMD_BANK_WORDS);
    localparam logic [IW-1:0] IDX_BASIC = IW'(0);
    localparam logic [IW-1:0] IDX_CMD   = IW'(1);
    localparam logic [IW-1:0] IDX_CFG   = IW'(8);

    logic [31:0] mem [CMD_BANK_WORDS];
    logic [31:0] mem_q_reg;
    logic [CMD_BANK_WORDS-1:0] valid_reg, valid_next;
    logic [31:0] basic_reg, basic_next;
    logic [31:0] cmd_reg, cmd_next;
    logic [31:0] cfg_reg, cfg_next;
    logic        byp_reg;
    logic [31:0] byp_data_reg;

    logic [IW-1:0] idx;
    logic [IW-1:0] rd_idx;
    logic          is_write;
    logic          do_clear;
    logic [31:0]   cword;

    assign idx    = op.reg_offset[IW+1:2];
    assign rd_idx = rd_offset[IW+1:2];
    assign bad    = (op.reg_offset[1:0] != 2'b00) ||
                    ({1'b0, op.reg_offset[9:2]} >= 9'(CMD_BANK_WORDS));
    assign is_write = fire && (op.req_type == REQ_WRITE) && (op.bank == BANK_CMD) && !bad;
    assign do_clear = fire && (op.req_type == REQ_RESET_LINE) && op.line_level;

    // Plain words come from memory and read zero until written; a word written
    // by the request just ahead of this one is taken from the bypass register.
    always_comb begin
        if (idx == IDX_BASIC) begin
            rd_word = basic_reg;
        end else if (idx == IDX_CMD) begin
            rd_word = cmd_reg;
        end else if (idx == IDX_CFG) begin
            rd_word = cfg_reg;
        end else if (!valid_reg[idx]) begin
            rd_word = '0;
        end else if (byp_reg) begin
            rd_word = byp_data_reg;
        end else begin
            rd_word = mem_q_reg;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        basic_next = basic_reg;
        cmd_next   = cmd_reg;
        cfg_next   = cfg_reg;
        cword      = '0;
        if (do_clear) begin
            valid_next = '0;
            basic_next = '0;
            cmd_next   = '0;
            cfg_next   = '0;
        end else if (is_write) begin
            valid_next[idx] = 1'b1;
            case (idx)
                IDX_BASIC: begin
                    basic_next = {op.write_data[31:4], op.write_data[2], op.write_data[2:0]};
                    if (op.write_data[0]) begin
                        cmd_next[13] = 1'b1;
                    end
                end
                IDX_CMD: begin
                    cword = op.write_data | {19'b0, op.write_data[4:0], 8'b0};
                    if (op.write_data[4]) begin
                        cword[31:24] = mode_readback(basic_reg, cfg_reg);
                    end
                    cmd_next = cword;
                end
                IDX_CFG: begin
                    cfg_next = op.write_data;
                end
                default: begin
                    cword = '0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (is_write) begin
            mem[idx] <= op.write_data;
        end
        if (rd_en) begin
            mem_q_reg    <= mem[rd_idx];
            byp_data_reg <= op.write_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            basic_reg <= '0;
            cmd_reg   <= '0;
            cfg_reg   <= '0;
            byp_reg   <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            basic_reg <= basic_next;
            cmd_reg   <= cmd_next;
            cfg_reg   <= cfg_next;
            if (rd_en) begin
                byp_reg <= is_write && (idx == rd_idx);
            end
        end
    end

endmodule

`default_nettype wire
